// File: hdl/conv3x3_edge_clamp_filter_top_assert.svh
// ----------------------------------------------------------------------------
// conv3x3_edge_clamp_filter_top_assert.svh
// Assertion macros for the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`ifndef CONV3X3_EDGE_CLAMP_FILTER_TOP_ASSERT_SVH
`define CONV3X3_EDGE_CLAMP_FILTER_TOP_ASSERT_SVH

// same-cycle implication
`define CFC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfc assertion failed");

// next-cycle implication
`define CFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfc assertion failed");

`endif

// File: hdl/cfc_pkg.sv
// ----------------------------------------------------------------------------
// cfc_pkg
// Shared constants, register map and control types of the 3x3 filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfc_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 11;
  localparam int KERN_W  = 24;
  localparam int DIV_W   = 11;
  localparam int BIAS_W  = 18;
  localparam int SIZE_W  = 12;
  localparam int ACC_W   = 21;
  localparam int MAG_W   = 20;
  localparam int REM_W   = DIV_W + 1;
  localparam int CNT_W   = $clog2(MAG_W);
  localparam int PIX_MAX = 255;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [2:0] REG_KERNEL_TOP    = 3'd0;
  localparam logic [2:0] REG_KERNEL_MIDDLE = 3'd1;
  localparam logic [2:0] REG_KERNEL_BOTTOM = 3'd2;
  localparam logic [2:0] REG_DIVISOR       = 3'd3;
  localparam logic [2:0] REG_BIAS          = 3'd4;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd5;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd6;

  localparam logic [KERN_W-1:0] KERNEL_TOP_RST    = 24'd0;
  localparam logic [KERN_W-1:0] KERNEL_MIDDLE_RST = 24'd256;
  localparam logic [KERN_W-1:0] KERNEL_BOTTOM_RST = 24'd0;
  localparam logic [DIV_W-1:0]  DIVISOR_RST       = 11'd1;
  localparam logic [BIAS_W-1:0] BIAS_RST          = 18'd0;
  localparam logic [SIZE_W-1:0] IMAGE_WIDTH_RST   = 12'd640;
  localparam logic [SIZE_W-1:0] IMAGE_HEIGHT_RST  = 12'd480;

  typedef struct packed {
    logic load;
    logic read;
    logic update;
    logic pick;
    logic mac;
    logic div_init;
    logic div_step;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic pending;
    logic mac_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// File: hdl/cfc_ctrl.sv
// ----------------------------------------------------------------------------
// cfc_ctrl
// Sequencer: pixel intake, line store update, then per output MAC and divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cfc_pkg::status_t  status,
  output cfc_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_READ     = 8'b0000_0010,
    S_UPDATE   = 8'b0000_0100,
    S_PICK     = 8'b0000_1000,
    S_MAC      = 8'b0001_0000,
    S_DIV_INIT = 8'b0010_0000,
    S_DIV      = 8'b0100_0000,
    S_PUSH     = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_UPDATE;
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_PICK;
      end
      S_PICK: begin
        if (status.pending) begin
          cmd.pick   = 1'b1;
          state_next = S_MAC;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MAC: begin
        cmd.mac = 1'b1;
        if (status.mac_last) begin
          state_next = S_DIV_INIT;
        end
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        if (status.out_free) begin
          cmd.push   = 1'b1;
          state_next = S_PICK;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/cfc_datapath.sv
// ----------------------------------------------------------------------------
// cfc_datapath
// Line stores, 3x3 window, row-wise MAC, bit-serial divider, output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfc_datapath #(
  parameter int MAX_WIDTH  = cfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfc_pkg::cmd_t                cmd,
  output cfc_pkg::status_t             status,
  input  logic [cfc_pkg::PIX_W-1:0]    pixel,
  input  logic [cfc_pkg::KERN_W-1:0]   kernel_top,
  input  logic [cfc_pkg::KERN_W-1:0]   kernel_middle,
  input  logic [cfc_pkg::KERN_W-1:0]   kernel_bottom,
  input  logic [cfc_pkg::DIV_W-1:0]    divisor,
  input  logic [cfc_pkg::BIAS_W-1:0]   bias,
  input  logic [cfc_pkg::SIZE_W-1:0]   image_width,
  input  logic [cfc_pkg::SIZE_W-1:0]   image_height,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cfc_pkg::PIX_W-1:0]    result_pixel,
  output logic [cfc_pkg::COORD_W-1:0]  column,
  output logic [cfc_pkg::COORD_W-1:0]  row,
  output logic                         divide_error,
  output logic                         frame_done,
  output logic                         last
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int WW = CW + 1;
  localparam int HW = RW + 1;
  localparam int PW = cfc_pkg::PIX_W;
  localparam int AW = cfc_pkg::ACC_W;
  localparam int MW = cfc_pkg::MAG_W;

  // effective frame size
  logic [31:0]   iw32, ih32;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  assign iw32 = 32'(image_width);
  assign ih32 = 32'(image_height);

  always_comb begin
    if (iw32 == 32'd0) begin
      w_eff = WW'(1);
    end else if (iw32 > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(iw32);
    end
    if (ih32 == 32'd0) begin
      h_eff = HW'(1);
    end else if (ih32 > 32'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(ih32);
    end
  end

  // position of the next word
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] px_in;
  logic [RW-1:0] py_in;
  logic [HW-1:0] row_inc;

  always_comb begin
    px_in   = col_count;
    row_inc = {1'b0, row_count};
    if ({1'b0, col_count} >= w_eff) begin
      px_in   = '0;
      row_inc = row_inc + 1'b1;
    end
    py_in = (row_inc >= h_eff) ? '0 : row_inc[RW-1:0];
  end

  logic [CW-1:0] px;
  logic [RW-1:0] py;
  logic [PW-1:0] pix_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px    <= px_in;
      py    <= py_in;
      pix_q <= pixel;
    end
  end

  // line stores
  logic [PW-1:0] older_line  [MAX_WIDTH];
  logic [PW-1:0] recent_line [MAX_WIDTH];
  logic [PW-1:0] old_q, rec_q;

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      old_q <= older_line[px];
      rec_q <= recent_line[px];
    end
    if (cmd.update) begin
      older_line[px]  <= rec_q;
      recent_line[px] <= pix_q;
    end
  end

  // new window column, top to bottom
  logic [PW-1:0] colv [3];

  always_comb begin
    colv[2] = pix_q;
    if (py == '0) begin
      colv[0] = pix_q;
      colv[1] = pix_q;
    end else if (py == RW'(1)) begin
      colv[0] = rec_q;
      colv[1] = rec_q;
    end else begin
      colv[0] = old_q;
      colv[1] = rec_q;
    end
  end

  logic [PW-1:0] win [3][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win[r][c] <= '0;
        end
      end
    end else if (cmd.update) begin
      for (int r = 0; r < 3; r++) begin
        if (px == '0) begin
          win[r][0] <= colv[r];
          win[r][1] <= colv[r];
        end else begin
          win[r][0] <= win[r][1];
          win[r][1] <= win[r][2];
        end
        win[r][2] <= colv[r];
      end
    end
  end

  // outputs due from this word: bit 0 (y-1,x-1), 1 (y-1,x), 2 (y,x-1), 3 (y,x)
  logic          px_nz, py_nz, px_edge, py_edge;
  logic [WW-1:0] col_inc;
  logic [HW-1:0] row_adv;

  assign px_nz   = (px != '0);
  assign py_nz   = (py != '0);
  assign px_edge = ({1'b0, px} == (w_eff - 1'b1));
  assign py_edge = ({1'b0, py} == (h_eff - 1'b1));
  assign col_inc = {1'b0, px} + 1'b1;
  assign row_adv = {1'b0, py} + 1'b1;

  logic [3:0] pend;
  logic [1:0] pick_idx;
  logic [3:0] pick_hot;

  always_comb begin
    if (pend[0]) begin
      pick_idx = 2'd0;
    end else if (pend[1]) begin
      pick_idx = 2'd1;
    end else if (pend[2]) begin
      pick_idx = 2'd2;
    end else begin
      pick_idx = 2'd3;
    end
    pick_hot = 4'b0001 << pick_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      pend      <= '0;
    end else if (cmd.update) begin
      pend <= {py_edge & px_edge, py_edge & px_nz, py_nz & px_edge, py_nz & px_nz};
      if (col_inc >= w_eff) begin
        col_count <= '0;
        row_count <= (row_adv >= h_eff) ? '0 : row_adv[RW-1:0];
      end else begin
        col_count <= col_inc[CW-1:0];
      end
    end else if (cmd.pick) begin
      pend <= pend & ~pick_hot;
    end
  end

  // current output
  logic          x_edge, y_edge, last_q, fdone_q;
  logic [CW-1:0] x_q;
  logic [RW-1:0] y_q;
  logic [CW-1:0] x_sel;
  logic [RW-1:0] y_sel;

  assign x_sel = pick_idx[0] ? px : px - 1'b1;
  assign y_sel = pick_idx[1] ? py : py - 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      x_edge  <= pick_idx[0];
      y_edge  <= pick_idx[1];
      x_q     <= x_sel;
      y_q     <= y_sel;
      last_q  <= ((pend & ~pick_hot) == 4'b0000);
      fdone_q <= ({1'b0, x_sel} == (w_eff - 1'b1)) && ({1'b0, y_sel} == (h_eff - 1'b1));
    end
  end

  // one kernel row per cycle
  logic [1:0]               step;
  logic [1:0]               r_sel;
  logic [cfc_pkg::KERN_W-1:0] krow;
  logic [PW-1:0]            wrow [3];
  logic signed [16:0]       prod [3];
  logic signed [AW-1:0]     row_sum;
  logic signed [AW-1:0]     acc;

  always_comb begin
    r_sel = y_edge ? ((step == 2'd0) ? 2'd1 : 2'd2) : step;
    case (step)
      2'd0:    krow = kernel_top;
      2'd1:    krow = kernel_middle;
      default: krow = kernel_bottom;
    endcase
    for (int c = 0; c < 3; c++) begin
      case (r_sel)
        2'd0:    wrow[c] = win[0][c];
        2'd1:    wrow[c] = win[1][c];
        default: wrow[c] = win[2][c];
      endcase
    end
    for (int c = 0; c < 3; c++) begin
      if (x_edge) begin
        prod[c] = $signed(krow[8*c +: 8]) * $signed({1'b0, wrow[(c == 0) ? 1 : 2]});
      end else begin
        prod[c] = $signed(krow[8*c +: 8]) * $signed({1'b0, wrow[c]});
      end
    end
    row_sum = AW'(prod[0]) + AW'(prod[1]) + AW'(prod[2]);
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      acc  <= '0;
      step <= '0;
    end else if (cmd.mac) begin
      acc  <= acc + row_sum;
      step <= step + 1'b1;
    end
  end

  // restoring divider on magnitudes, one quotient bit a cycle
  logic [MW-1:0]                 quo;
  logic [cfc_pkg::REM_W-1:0]     rem, rem_sh;
  logic [cfc_pkg::DIV_W-1:0]     dmag;
  logic [cfc_pkg::CNT_W-1:0]     cnt;
  logic                          neg_q, err_q, q_bit;

  assign rem_sh = {rem[cfc_pkg::REM_W-2:0], quo[MW-1]};
  assign q_bit  = (rem_sh >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo   <= acc[AW-1] ? MW'(-acc) : MW'(acc);
      dmag  <= divisor[cfc_pkg::DIV_W-1] ? -divisor : divisor;
      rem   <= '0;
      cnt   <= cfc_pkg::CNT_W'(MW - 1);
      neg_q <= acc[AW-1] ^ divisor[cfc_pkg::DIV_W-1];
      err_q <= (divisor == '0);
    end else if (cmd.div_step) begin
      rem <= q_bit ? (rem_sh - {1'b0, dmag}) : rem_sh;
      quo <= {quo[MW-2:0], q_bit};
      cnt <= cnt - 1'b1;
    end
  end

  // sign, bias, clamp
  logic signed [AW-1:0] qs;
  logic signed [AW:0]   fsum;
  logic [PW-1:0]        fpix;
  logic [31:0]          x32, y32;

  always_comb begin
    qs   = neg_q ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    fsum = (AW+1)'(qs) + (AW+1)'($signed(bias));
    if (err_q || fsum < 0) begin
      fpix = '0;
    end else if (fsum > (AW+1)'(cfc_pkg::PIX_MAX)) begin
      fpix = PW'(cfc_pkg::PIX_MAX);
    end else begin
      fpix = fsum[PW-1:0];
    end
  end

  assign x32 = 32'(x_q);
  assign y32 = 32'(y_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      result_pixel <= fpix;
      column       <= x32[cfc_pkg::COORD_W-1:0];
      row          <= y32[cfc_pkg::COORD_W-1:0];
      divide_error <= err_q;
      frame_done   <= fdone_q;
      last         <= last_q;
    end
  end

  assign status.pending  = (pend != 4'b0000);
  assign status.mac_last = (step == 2'd2);
  assign status.div_last = (cnt == '0);
  assign status.out_free = !out_valid || out_ready;

endmodule

// File: hdl/conv3x3_edge_clamp_filter_top.sv
// ----------------------------------------------------------------------------
// conv3x3_edge_clamp_filter_top
// 3x3 convolution of a raster pixel stream with replicated borders.
// ----------------------------------------------------------------------------
// One pixel word is taken at a time. Intake reads and then updates the line
// stores; each output then runs a MAC step per kernel row, divider setup, the
// iterations of the one-bit-per-cycle divider, push (which waits while the
// output register is full) and select. A pixel causes 0 to 4 outputs, and the
// divider takes the largest share of each. The output register lets the next
// pixel be taken while the last result still waits.
`timescale 1ns / 1ps

`include "conv3x3_edge_clamp_filter_top_assert.svh"

module conv3x3_edge_clamp_filter_top #(
  parameter int MAX_WIDTH  = cfc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = cfc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfc_pkg::PADDR_W-1:0]   paddr,
  input  logic [cfc_pkg::PDATA_W-1:0]   pwdata,
  output logic [cfc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cfc_pkg::PIX_W-1:0]     pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cfc_pkg::PIX_W-1:0]     result_pixel,
  output logic [cfc_pkg::COORD_W-1:0]   column,
  output logic [cfc_pkg::COORD_W-1:0]   row,
  output logic                          divide_error,
  output logic                          frame_done,
  output logic                          last
);

  logic [cfc_pkg::KERN_W-1:0] kernel_top, kernel_middle, kernel_bottom;
  logic [cfc_pkg::DIV_W-1:0]  divisor;
  logic [cfc_pkg::BIAS_W-1:0] bias;
  logic [cfc_pkg::SIZE_W-1:0] image_width, image_height;
  logic [2:0]                 reg_idx;
  logic                       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_top    <= cfc_pkg::KERNEL_TOP_RST;
      kernel_middle <= cfc_pkg::KERNEL_MIDDLE_RST;
      kernel_bottom <= cfc_pkg::KERNEL_BOTTOM_RST;
      divisor       <= cfc_pkg::DIVISOR_RST;
      bias          <= cfc_pkg::BIAS_RST;
      image_width   <= cfc_pkg::IMAGE_WIDTH_RST;
      image_height  <= cfc_pkg::IMAGE_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        cfc_pkg::REG_KERNEL_TOP:    kernel_top    <= pwdata[cfc_pkg::KERN_W-1:0];
        cfc_pkg::REG_KERNEL_MIDDLE: kernel_middle <= pwdata[cfc_pkg::KERN_W-1:0];
        cfc_pkg::REG_KERNEL_BOTTOM: kernel_bottom <= pwdata[cfc_pkg::KERN_W-1:0];
        cfc_pkg::REG_DIVISOR:       divisor       <= pwdata[cfc_pkg::DIV_W-1:0];
        cfc_pkg::REG_BIAS:          bias          <= pwdata[cfc_pkg::BIAS_W-1:0];
        cfc_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[cfc_pkg::SIZE_W-1:0];
        cfc_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[cfc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      cfc_pkg::REG_KERNEL_TOP:    prdata = cfc_pkg::PDATA_W'(kernel_top);
      cfc_pkg::REG_KERNEL_MIDDLE: prdata = cfc_pkg::PDATA_W'(kernel_middle);
      cfc_pkg::REG_KERNEL_BOTTOM: prdata = cfc_pkg::PDATA_W'(kernel_bottom);
      cfc_pkg::REG_DIVISOR:       prdata = cfc_pkg::PDATA_W'(divisor);
      cfc_pkg::REG_BIAS:          prdata = cfc_pkg::PDATA_W'(bias);
      cfc_pkg::REG_IMAGE_WIDTH:   prdata = cfc_pkg::PDATA_W'(image_width);
      cfc_pkg::REG_IMAGE_HEIGHT:  prdata = cfc_pkg::PDATA_W'(image_height);
      default:                    prdata = '0;
    endcase
  end

  cfc_pkg::cmd_t    cmd;
  cfc_pkg::status_t status;

  cfc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  cfc_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .pixel         (pixel),
    .kernel_top    (kernel_top),
    .kernel_middle (kernel_middle),
    .kernel_bottom (kernel_bottom),
    .divisor       (divisor),
    .bias          (bias),
    .image_width   (image_width),
    .image_height  (image_height),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .result_pixel  (result_pixel),
    .column        (column),
    .row           (row),
    .divide_error  (divide_error),
    .frame_done    (frame_done),
    .last          (last)
  );

  `CFC_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
  `CFC_ASSERT_SAME(a_err_zero_pixel, out_valid && divide_error, result_pixel == '0)
  `CFC_ASSERT_SAME(a_frame_done_last, out_valid && frame_done, last)
  `CFC_ASSERT_SAME(a_partial_blocks_intake, out_valid && !last, !in_ready)

endmodule

// File: test/tb_conv3x3_edge_clamp_filter_top.sv
// ----------------------------------------------------------------------------
// tb_conv3x3_edge_clamp_filter_top
// Self-checking bench for the 3x3 convolution filter with replicated borders.
// Frames, whole or cut short, are streamed under changing register settings; a
// local model of the line stores and window predicts every output word, which is
// checked in full and in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_conv3x3_edge_clamp_filter_top;

  typedef struct packed {
    logic [cfc_pkg::PIX_W-1:0]   value;
    logic [cfc_pkg::COORD_W-1:0] x;
    logic [cfc_pkg::COORD_W-1:0] y;
    logic                        err;
    logic                        fdone;
    logic                        lst;
  } filt_word_t;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [cfc_pkg::PADDR_W-1:0] paddr = '0;
  logic [cfc_pkg::PDATA_W-1:0] pwdata = '0;
  logic [cfc_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 0, in_ready;
  logic [cfc_pkg::PIX_W-1:0] pixel = '0;
  logic out_valid, out_ready = 0;
  logic [cfc_pkg::PIX_W-1:0] result_pixel;
  logic [cfc_pkg::COORD_W-1:0] column, row;
  logic divide_error, frame_done, last;

  conv3x3_edge_clamp_filter_top u_top (.*);

  always #1 clk = ~clk;

  // local copy of registers and state
  logic [23:0] k_rows [3];
  logic [10:0] div_reg;
  logic [17:0] bias_reg;
  logic [11:0] width_reg, height_reg;
  logic [7:0]  line_old [2048];
  logic [7:0]  line_new [2048];
  logic [7:0]  win [9];
  int unsigned col_pos, row_pos;

  filt_word_t  expected_words[$];
  logic [7:0]  pixel_queue[$];
  bit in_taken = 0, no_idle = 0;
  int in_gap = 0, out_gap = 0, hold_cycles = 0;
  int mismatches = 0, pixels_sent = 0, words_seen = 0, phases = 0;

  function automatic int unsigned eff_size(logic [11:0] v);
    if (v == 0) return 1;
    return (v > 2048) ? 2048 : v;
  endfunction

  function automatic filt_word_t convolve(int rs[3], int cs[3], int unsigned x,
                                          int unsigned y);
    filt_word_t o;
    int acc, d;
    acc = 0;
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        acc += int'($signed(k_rows[r][8*c +: 8])) * int'(win[(rs[r]*3 + cs[c]) % 9]);
    d = int'($signed(div_reg));
    o = '0;
    o.x = x[10:0];
    o.y = y[10:0];
    if (d == 0) begin
      o.err = 1;
    end else begin
      acc = acc / d + int'($signed(bias_reg));
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      o.value = acc[7:0];
    end
    return o;
  endfunction

  task automatic predict_pixel(logic [7:0] p);
    int unsigned w, h, px, py, n;
    logic [7:0] t, m;
    logic [7:0] colv [3];
    int inner[3], edge_ix[3], rsel[3], csel[3];
    filt_word_t o;
    inner = '{0, 1, 2};
    edge_ix = '{1, 2, 2};
    w = eff_size(width_reg);
    h = eff_size(height_reg);
    if (col_pos >= w) begin col_pos = 0; row_pos++; end
    if (row_pos >= h) row_pos = 0;
    px = col_pos; py = row_pos;
    t = (py >= 2) ? line_old[px] : line_new[px];
    m = (py >= 1) ? line_new[px] : p;
    if (py == 0) t = p;
    line_old[px] = line_new[px];
    line_new[px] = p;
    colv = '{t, m, p};
    for (int r = 0; r < 3; r++) begin
      if (px == 0) begin
        win[r*3] = colv[r];
        win[r*3+1] = colv[r];
      end else begin
        win[r*3] = win[r*3+1];
        win[r*3+1] = win[r*3+2];
      end
      win[r*3+2] = colv[r];
    end
    n = 0;
    for (int yi = 0; yi < 2; yi++) begin
      if (yi == 0 && py == 0) continue;
      if (yi == 1 && py != h - 1) continue;
      for (int xi = 0; xi < 2; xi++) begin
        if (xi == 0 && px == 0) continue;
        if (xi == 1 && px != w - 1) continue;
        if (yi == 0) rsel = inner;
        else rsel = edge_ix;
        if (xi == 0) csel = inner;
        else csel = edge_ix;
        o = convolve(rsel, csel, xi == 0 ? px - 1 : px, yi == 0 ? py - 1 : py);
        o.fdone = ((xi == 0 ? px - 1 : px) == w - 1) &&
                  ((yi == 0 ? py - 1 : py) == h - 1);
        expected_words.push_back(o);
        n++;
      end
    end
    if (n > 0) expected_words[$].lst = 1;
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endtask

  // sampling at the rising edge
  always @(posedge clk) begin
    filt_word_t got, exp_w;
    if (!rst) begin
      if (in_valid && in_ready) begin
        in_taken = 1;
        predict_pixel(pixel);
      end
      if (out_valid && out_ready) begin
        got = '{result_pixel, column, row, divide_error, frame_done, last};
        words_seen++;
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", got);
        end else begin
          exp_w = expected_words.pop_front();
          if (got !== exp_w) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_w, got);
          end
        end
      end
    end
  end

  // pixel driver
  always @(negedge clk) begin
    logic nv;
    if (!rst && (!in_valid || in_taken)) begin
      in_taken = 0;
      nv = 0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (pixel_queue.size() > 0) begin
        pixel <= pixel_queue.pop_front();
        nv = 1;
        pixels_sent++;
        in_gap = no_idle ? 0 : $urandom_range(0, 6);
      end
      in_valid <= nv;
    end
  end

  // output receiver
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ready <= 0;
      end else if (out_valid && out_ready) begin
        out_gap = no_idle ? 0 : $urandom_range(0, 6);
        out_ready <= (out_gap == 0);
      end else if (out_gap > 0) begin
        out_gap--;
        out_ready <= (out_gap == 0);
      end else begin
        out_ready <= 1;
      end
    end
  end

  task automatic apb_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel = 1; penable = 0; pwrite = 1;
    paddr = cfc_pkg::PADDR_W'({idx, 2'b00});
    pwdata = v;
    @(negedge clk);
    penable = 1;
    @(negedge clk);
    psel = 0; penable = 0; pwrite = 0;
    case (idx)
      cfc_pkg::REG_KERNEL_TOP:    k_rows[0] = v[23:0];
      cfc_pkg::REG_KERNEL_MIDDLE: k_rows[1] = v[23:0];
      cfc_pkg::REG_KERNEL_BOTTOM: k_rows[2] = v[23:0];
      cfc_pkg::REG_DIVISOR:       div_reg = v[10:0];
      cfc_pkg::REG_BIAS:          bias_reg = v[17:0];
      cfc_pkg::REG_IMAGE_WIDTH:   width_reg = v[11:0];
      default:                    height_reg = v[11:0];
    endcase
  endtask

  task automatic wait_idle();
    while (pixel_queue.size() > 0 || in_valid || expected_words.size() > 0)
      @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // fill: 0 random, 1 all 255, 2 alternate 0/255; cap > 0 limits the run to cap pixels
  task automatic run_frames(logic [23:0] kt, logic [23:0] km, logic [23:0] kb,
                            logic [10:0] dv, logic [17:0] bs, logic [11:0] w,
                            logic [11:0] h, int frames, int fill, int cap);
    int total;
    wait_idle();
    apb_write(cfc_pkg::REG_KERNEL_TOP, kt);
    apb_write(cfc_pkg::REG_KERNEL_MIDDLE, km);
    apb_write(cfc_pkg::REG_KERNEL_BOTTOM, kb);
    apb_write(cfc_pkg::REG_DIVISOR, dv);
    apb_write(cfc_pkg::REG_BIAS, bs);
    apb_write(cfc_pkg::REG_IMAGE_WIDTH, w);
    apb_write(cfc_pkg::REG_IMAGE_HEIGHT, h);
    phases++;
    total = frames * eff_size(w) * eff_size(h);
    if (cap > 0 && total > cap) total = cap;
    for (int i = 0; i < total; i++)
      pixel_queue.push_back(fill == 1 ? 8'hFF : fill == 2 ? ((i & 1) ? 8'hFF : 8'h00)
                                                         : 8'($urandom));
  endtask

  initial begin
    int rnd_start;
    k_rows = '{cfc_pkg::KERNEL_TOP_RST, cfc_pkg::KERNEL_MIDDLE_RST,
               cfc_pkg::KERNEL_BOTTOM_RST};
    div_reg = cfc_pkg::DIVISOR_RST; bias_reg = cfc_pkg::BIAS_RST;
    width_reg = cfc_pkg::IMAGE_WIDTH_RST; height_reg = cfc_pkg::IMAGE_HEIGHT_RST;
    foreach (win[i]) win[i] = 0;
    col_pos = 0; row_pos = 0;
    repeat (9) @(posedge clk);
    rst <= 0;

    // directed settings
    run_frames(24'h0, 24'h100, 24'h0, 11'd1, 18'd0, 12'd1, 12'd1, 1, 1, 0);
    run_frames(24'h0, 24'h100, 24'h0, 11'd1, 18'd0, 12'd0, 12'd0, 2, 2, 0);
    run_frames(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 11'd1, 18'd0, 12'd3, 12'd3, 1, 2, 0);
    run_frames(24'h808080, 24'h808080, 24'h808080, 11'h400, 18'h20000, 12'd2, 12'd2,
               1, 1, 0);
    run_frames(24'h808080, 24'h7F0080, 24'h01FF7F, 11'h7FF, 18'h1FFFF, 12'd4, 12'd1,
               1, 2, 0);
    run_frames(24'h010203, 24'hFF0410, 24'h7F8001, 11'd0, 18'd5, 12'd2, 12'd3, 1, 0, 0);
    run_frames(24'h0, 24'h100, 24'h0, 11'h3FF, 18'h3FF00, 12'd1, 12'd4, 1, 2, 0);

    // random settings, small frames
    rnd_start = pixels_sent + pixel_queue.size();
    while (pixels_sent + pixel_queue.size() - rnd_start < 100) begin
      no_idle = ($urandom_range(0, 4) == 0);
      run_frames(24'($urandom), 24'($urandom), 24'($urandom),
                 ($urandom_range(0, 7) == 0) ? 11'd0 : 11'($urandom),
                 ($urandom_range(0, 1)) ? 18'($urandom) : 18'($signed(9'($urandom))),
                 12'($urandom_range(1, 10)), 12'($urandom_range(1, 6)),
                 $urandom_range(1, 2), 0, 0);
      if (phases == 8) begin
        no_idle = 1;
        hold_cycles = 600;
      end
    end
    no_idle = 0;

    // oversized settings, start of a frame only
    run_frames(24'h010101, 24'h010101, 24'h010101, 11'd9, 18'd0, 12'd1, 12'd4095,
               1, 0, 12);
    run_frames(24'hFF01FF, 24'h0302FE, 24'h01FF01, 11'd3, 18'd40, 12'd4095, 12'd1,
               1, 0, 12);
    wait_idle();

    $display("covered %0d phases, %0d pixels in, %0d filtered words out",
             phases, pixels_sent, words_seen);
    $display("sizes from 1x1 up, oversized sizes, zero divisor, extreme kernels, stalls");
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS conv3x3_edge_clamp_filter_top");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_words.size());
      $display("FAIL conv3x3_edge_clamp_filter_top");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("timeout");
    $display("FAIL conv3x3_edge_clamp_filter_top");
    $finish;
  end

endmodule
